>>> rtl/rsa_pe_pkg.sv
package rsa_pe_pkg;

   // operand widths
   localparam int PRIME_WIDTH = 31;
   localparam int PORT_PRIME_WIDTH = 31;
   localparam int EXP_WIDTH = 62;
   // coefficient register, two's complement, wide enough for +/- totient
   localparam int COEF_WIDTH = 64;

   // euclid step bound and counter widths
   localparam int MAX_STEPS = 128;
   localparam int STEP_WIDTH = $clog2(MAX_STEPS) + 1;
   localparam int BIT_CNT_WIDTH = $clog2(EXP_WIDTH);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULT,
      ST_CHECK,
      ST_DIV,
      ST_SETUP,
      ST_TEST,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/rsa_private_exponent_unit.sv
// channel  direction  signals
// req      in         req_valid, req_ready, req_prime_p, req_prime_q, req_public_exponent
// rsp      out        rsp_valid, rsp_ready, rsp_private_exponent, rsp_inverse_exists
//
// one transaction at a time; req_ready is high only while the sequencer is idle.
// a single restoring divider (one quotient bit per cycle) serves both the
// reduction of e by the totient and every euclid step; it also folds quotient times
// coefficient in by shift-add. the euclid loop ends on a zero remainder or at MAX_STEPS steps.
// synchronous active-high reset clears the sequencer and the output valid.
// a finished result waits in the output register; the next request is taken meanwhile,
// and the sequencer only stalls at its end if the previous result is still not taken.
module rsa_private_exponent_unit
   import rsa_pe_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PORT_PRIME_WIDTH-1:0] req_prime_p,
   input  logic [PORT_PRIME_WIDTH-1:0] req_prime_q,
   input  logic [EXP_WIDTH-1:0]        req_public_exponent,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [EXP_WIDTH-1:0]        rsp_private_exponent,
   output logic                        rsp_inverse_exists
);

   state_type state_ff, state_in;

   logic [PRIME_WIDTH-1:0]   pm1_ff, pm1_in, qm1_ff, qm1_in;
   logic [EXP_WIDTH-1:0]     e_ff, e_in;
   logic [EXP_WIDTH-1:0]     m_ff, m_in;
   logic [EXP_WIDTH-1:0]     r_prev_ff, r_prev_in, r_cur_ff, r_cur_in;
   logic [COEF_WIDTH-1:0]    t_prev_ff, t_prev_in, t_cur_ff, t_cur_in;
   logic [EXP_WIDTH-1:0]     dvd_ff, dvd_in, dvsr_ff, dvsr_in, rem_ff, rem_in;
   logic [COEF_WIDTH-1:0]    acc_ff, acc_in;
   logic [BIT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic                     red_mode_ff, red_mode_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [EXP_WIDTH-1:0]     rsp_exp_ff, rsp_exp_in;
   logic                     rsp_ok_ff, rsp_ok_in;

   logic [PRIME_WIDTH-1:0]   p_field, q_field;
   logic [2*PRIME_WIDTH-1:0] product;
   logic [EXP_WIDTH:0]       rem_shift;
   logic                     quo_bit;
   logic [EXP_WIDTH-1:0]     rem_step;
   logic [COEF_WIDTH-1:0]    acc_step;
   logic [COEF_WIDTH-1:0]    inv_raw;
   logic                     inv_ok;
   logic [EXP_WIDTH-1:0]     inv_final;

   // input fields, p-1 and q-1 saturating at zero
   assign p_field = req_prime_p[PRIME_WIDTH-1:0];
   assign q_field = req_prime_q[PRIME_WIDTH-1:0];

   // totient multiplier
   assign product = pm1_ff * qm1_ff;

   // restoring divider step, quotient times coefficient folded in msb first
   assign rem_shift = {rem_ff, dvd_ff[EXP_WIDTH-1]};
   assign quo_bit   = (rem_shift >= {1'b0, dvsr_ff});
   assign rem_step  = quo_bit ? EXP_WIDTH'(rem_shift - {1'b0, dvsr_ff})
                              : rem_shift[EXP_WIDTH-1:0];
   assign acc_step  = (acc_ff << 1) + (quo_bit ? t_cur_ff : '0);

   // final coefficient brought into [0, totient)
   assign inv_raw   = t_prev_ff[COEF_WIDTH-1] ? (t_prev_ff + COEF_WIDTH'(m_ff))
                                              : t_prev_ff;
   assign inv_ok    = (r_prev_ff == EXP_WIDTH'(1));
   assign inv_final = (inv_ok && (inv_raw < COEF_WIDTH'(m_ff))) ?
                      inv_raw[EXP_WIDTH-1:0] : '0;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pm1_ff      <= pm1_in;
      qm1_ff      <= qm1_in;
      e_ff        <= e_in;
      m_ff        <= m_in;
      r_prev_ff   <= r_prev_in;
      r_cur_ff    <= r_cur_in;
      t_prev_ff   <= t_prev_in;
      t_cur_ff    <= t_cur_in;
      dvd_ff      <= dvd_in;
      dvsr_ff     <= dvsr_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      red_mode_ff <= red_mode_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in    = state_ff;
      pm1_in      = pm1_ff;
      qm1_in      = qm1_ff;
      e_in        = e_ff;
      m_in        = m_ff;
      r_prev_in   = r_prev_ff;
      r_cur_in    = r_cur_ff;
      t_prev_in   = t_prev_ff;
      t_cur_in    = t_cur_ff;
      dvd_in      = dvd_ff;
      dvsr_in     = dvsr_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      step_in     = step_ff;
      red_mode_in = red_mode_ff;
      rsp_exp_in  = rsp_exp_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready);
      req_ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pm1_in   = (p_field == '0) ? '0 : p_field - PRIME_WIDTH'(1);
               qm1_in   = (q_field == '0) ? '0 : q_field - PRIME_WIDTH'(1);
               e_in     = req_public_exponent;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            m_in     = EXP_WIDTH'(product);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (m_ff == '0) begin
               // no totient, report no inverse
               r_prev_in = '0;
               state_in  = ST_FINISH;
            end else begin
               // reduce e modulo the totient
               dvd_in      = e_ff;
               dvsr_in     = m_ff;
               rem_in      = '0;
               acc_in      = '0;
               cnt_in      = '0;
               red_mode_in = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in = dvd_ff << 1;
            rem_in = rem_step;
            acc_in = acc_step;
            cnt_in = cnt_ff + BIT_CNT_WIDTH'(1);
            if (cnt_ff == BIT_CNT_WIDTH'(EXP_WIDTH - 1)) begin
               state_in = red_mode_ff ? ST_SETUP : ST_UPDATE;
            end
         end
         ST_SETUP: begin
            r_prev_in = m_ff;
            r_cur_in  = rem_ff;
            t_prev_in = '0;
            t_cur_in  = COEF_WIDTH'(1);
            step_in   = '0;
            state_in  = ST_TEST;
         end
         ST_TEST: begin
            if ((r_cur_ff == '0) || (step_ff == STEP_WIDTH'(MAX_STEPS))) begin
               state_in = ST_FINISH;
            end else begin
               dvd_in      = r_prev_ff;
               dvsr_in     = r_cur_ff;
               rem_in      = '0;
               acc_in      = '0;
               cnt_in      = '0;
               red_mode_in = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_UPDATE: begin
            // shift the remainder and coefficient pairs
            r_prev_in = r_cur_ff;
            r_cur_in  = rem_ff;
            t_prev_in = t_cur_ff;
            t_cur_in  = t_prev_ff - acc_ff;
            step_in   = step_ff + STEP_WIDTH'(1);
            state_in  = ST_TEST;
         end
         ST_FINISH: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_exp_in   = inv_final;
               rsp_ok_in    = inv_ok;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_private_exponent = rsp_exp_ff;
   assign rsp_inverse_exists   = rsp_ok_ff;

endmodule

>>> test/rsa_private_exponent_checker.sv
module rsa_private_exponent_checker
   import rsa_pe_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [PORT_PRIME_WIDTH-1:0] req_prime_p,
   input  logic [PORT_PRIME_WIDTH-1:0] req_prime_q,
   input  logic [EXP_WIDTH-1:0]        req_public_exponent,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [EXP_WIDTH-1:0]        rsp_private_exponent,
   input  logic                        rsp_inverse_exists,
   output int                          mismatch_count,
   output int                          pending_keys
);

   typedef struct {
      logic [EXP_WIDTH-1:0] exponent;
      logic                 exists;
   } key_result_type;

   // keys predicted for accepted requests, oldest first
   key_result_type expected_keys[$];
   key_result_type oldest_key;

   initial begin
      mismatch_count = 0;
      pending_keys = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // inverse of e modulo (p-1)(q-1) by extended euclid, flag clear when gcd is not one
   function automatic key_result_type predict_private_exponent(
      input logic [PORT_PRIME_WIDTH-1:0] p_in,
      input logic [PORT_PRIME_WIDTH-1:0] q_in,
      input logic [EXP_WIDTH-1:0]        e_in
   );
      longint unsigned p_less, q_less, totient;
      longint unsigned r_prev, r_cur, r_next, quo, inverse;
      longint          t_prev, t_cur, t_next;
      key_result_type  key;
      key.exponent = '0;
      key.exists = 1'b0;
      p_less = 64'(p_in) & ((64'd1 << PRIME_WIDTH) - 64'd1);
      q_less = 64'(q_in) & ((64'd1 << PRIME_WIDTH) - 64'd1);
      // p-1 and q-1 saturate at zero
      if (p_less != 0) p_less = p_less - 1;
      if (q_less != 0) q_less = q_less - 1;
      totient = p_less * q_less;
      if (totient == 0) return key;
      r_prev = totient;
      r_cur = 64'(e_in) % totient;
      t_prev = 0;
      t_cur = 1;
      for (int step = 0; step < MAX_STEPS && r_cur != 0; step++) begin
         quo = r_prev / r_cur;
         r_next = r_prev - quo * r_cur;
         t_next = t_prev - $signed(quo) * t_cur;
         r_prev = r_cur;
         r_cur = r_next;
         t_prev = t_cur;
         t_cur = t_next;
      end
      if (r_prev != 1) return key;
      // fold a negative coefficient back into 0 .. totient-1
      if (t_prev < 0) inverse = totient - $unsigned(-t_prev);
      else inverse = $unsigned(t_prev);
      if (inverse >= totient) inverse = 0;
      key.exponent = inverse[EXP_WIDTH-1:0];
      key.exists = 1'b1;
      return key;
   endfunction

   // predict on each request transaction, compare on each response transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_keys.push_back(predict_private_exponent(req_prime_p, req_prime_q,
                                                             req_public_exponent));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_keys.size() == 0) begin
               report_mismatch("response transaction with no request pending");
            end else begin
               oldest_key = expected_keys.pop_front();
               if (rsp_private_exponent !== oldest_key.exponent)
                  report_mismatch($sformatf("private_exponent got %0d want %0d",
                                            rsp_private_exponent, oldest_key.exponent));
               if (rsp_inverse_exists !== oldest_key.exists)
                  report_mismatch($sformatf("inverse_exists got %0b want %0b",
                                            rsp_inverse_exists, oldest_key.exists));
            end
         end
         pending_keys = expected_keys.size();
      end
   end

endmodule

>>> test/rsa_private_exponent_unit_tb.sv
module rsa_private_exponent_unit_tb
   import rsa_pe_pkg::*;
();

   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 8;
   localparam int RANDOM_ITEMS     = 100;
   localparam int LONG_HOLD_CYCLES = 15000;
   localparam int HOLD_AFTER_SENT  = 40;
   localparam int DRAIN_CYCLES     = 6500;
   localparam int TIMEOUT_CYCLES   = 5000000;

   localparam logic [PORT_PRIME_WIDTH-1:0] PRIME_MAX = '1;
   localparam logic [EXP_WIDTH-1:0]        EXP_MAX   = '1;
   // consecutive fibonacci numbers give the longest euclid chain
   localparam logic [PORT_PRIME_WIDTH-1:0] FIB_P = 31'd701408734;
   localparam logic [PORT_PRIME_WIDTH-1:0] FIB_Q = 31'd1568397608;
   localparam logic [EXP_WIDTH-1:0]        FIB_E = 62'd679891637638612258;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [PORT_PRIME_WIDTH-1:0] req_prime_p;
   logic [PORT_PRIME_WIDTH-1:0] req_prime_q;
   logic [EXP_WIDTH-1:0]        req_public_exponent;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [EXP_WIDTH-1:0]        rsp_private_exponent;
   logic                        rsp_inverse_exists;
   int                          mismatch_count;
   int                          pending_keys;
   int                          sent_count;

   rsa_private_exponent_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_prime_p          (req_prime_p),
      .req_prime_q          (req_prime_q),
      .req_public_exponent  (req_public_exponent),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_private_exponent (rsp_private_exponent),
      .rsp_inverse_exists   (rsp_inverse_exists)
   );

   rsa_private_exponent_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_prime_p          (req_prime_p),
      .req_prime_q          (req_prime_q),
      .req_public_exponent  (req_public_exponent),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_private_exponent (rsp_private_exponent),
      .rsp_inverse_exists   (rsp_inverse_exists),
      .mismatch_count       (mismatch_count),
      .pending_keys         (pending_keys)
   );

   // clock
   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // hard stop
   initial begin
      #(longint'(CLOCK_PERIOD) * TIMEOUT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [PORT_PRIME_WIDTH-1:0] random_prime_field();
      return PORT_PRIME_WIDTH'($urandom);
   endfunction

   function automatic logic [EXP_WIDTH-1:0] random_exponent_field();
      return EXP_WIDTH'({$urandom, $urandom});
   endfunction

   // one request transaction, held until accepted
   task automatic send_key_request(input logic [PORT_PRIME_WIDTH-1:0] p,
                                   input logic [PORT_PRIME_WIDTH-1:0] q,
                                   input logic [EXP_WIDTH-1:0] e);
      @(negedge clock);
      req_valid <= 1'b1;
      req_prime_p <= p;
      req_prime_q <= q;
      req_public_exponent <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop offering until every outstanding key is back
   task automatic wait_for_all_keys();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_keys != 0) @(negedge clock);
   endtask

   // response side: random stretches of ready patterns and one long hold-off
   initial begin
      ready_mode_type mode;
      int             seg_left;
      int             hold_left;
      bit             hold_done;
      mode = READY_ALWAYS;
      seg_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && sent_count >= HOLD_AFTER_SENT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 2));
               seg_left = $urandom_range(1, 300);
            end
            seg_left--;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               default:      rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // request side and verdict
   initial begin
      logic [PORT_PRIME_WIDTH-1:0] p;
      logic [PORT_PRIME_WIDTH-1:0] q;
      logic [EXP_WIDTH-1:0]        e;
      longint unsigned             totient;
      int                          burst_left;
      sent_count = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_prime_p = '0;
      req_prime_q = '0;
      req_public_exponent = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: degenerate totients, extremes, textbook key, deepest chain
      send_key_request(31'd0, 31'd7, 62'd3);
      send_key_request(31'd1, PRIME_MAX, EXP_MAX);
      send_key_request(31'd0, 31'd0, 62'd0);
      send_key_request(31'd2, 31'd2, 62'd0);
      send_key_request(31'd2, 31'd2, EXP_MAX);
      send_key_request(31'd11, 31'd13, 62'd0);
      send_key_request(31'd11, 31'd13, 62'd1);
      send_key_request(31'd11, 31'd13, 62'd119);
      send_key_request(31'd11, 31'd13, 62'd6);
      send_key_request(31'd61, 31'd53, 62'd17);
      send_key_request(31'd61, 31'd53, 62'd15617);
      send_key_request(31'd3, 31'd3, 62'd2);
      send_key_request(31'd3, 31'd3, 62'd3);
      send_key_request(PRIME_MAX, 31'd2, 62'd0);
      send_key_request(PRIME_MAX, PRIME_MAX, 62'd65537);
      send_key_request(PRIME_MAX, PRIME_MAX, EXP_MAX);
      send_key_request(FIB_P, FIB_Q, FIB_E);
      wait_for_all_keys();

      // random: mostly well-formed keys, some degenerate and oversized inputs
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS * 3 / 5) wait_for_all_keys();
         if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
         p = random_prime_field();
         q = random_prime_field();
         e = random_exponent_field();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               totient = 64'(p - 1) * 64'(q - 1);
               if (p > 1 && q > 1) e = EXP_WIDTH'(64'(e) % totient);
            end
            4: begin
               case ($urandom_range(0, 2))
                  0: e = 62'd3;
                  1: e = 62'd17;
                  default: e = 62'd65537;
               endcase
            end
            5: begin
               p = PORT_PRIME_WIDTH'($urandom_range(0, 1000));
               q = PORT_PRIME_WIDTH'($urandom_range(0, 1000));
               e = EXP_WIDTH'($urandom_range(0, 2000));
            end
            6: ;
            7: begin
               if ($urandom_range(0, 1)) p = PORT_PRIME_WIDTH'($urandom_range(0, 2));
               else q = PORT_PRIME_WIDTH'($urandom_range(0, 2));
            end
            default: begin
               totient = 64'(p - 1) * 64'(q - 1);
               if ($urandom_range(0, 1)) e = '0;
               else if (p > 1 && q > 1) e = EXP_WIDTH'(totient - $urandom_range(0, 3));
            end
         endcase
         send_key_request(p, q, e);
      end

      wait_for_all_keys();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_keys == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
